// ===== rtl/lkc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkc_pkg: shared definitions for the LRU key cache cost unit
// Sizes, cost codes, register map, the cell control struct and key folding.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int ENTRIES   = 32;
  localparam int KEY_CHARS = 8;

  localparam int IN_KEY_W = 64;
  localparam int KEY_W    = 8 * KEY_CHARS;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CAP_W    = 6;
  localparam int CMP_W    = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int COST_W   = 3;

  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;

  localparam logic [COST_W-1:0] COST_HIT  = 3'd1;
  localparam logic [COST_W-1:0] COST_MISS = 3'd5;
  localparam logic [CAP_W-1:0]  CAP_RESET = 6'd32;

  // register word index within the configuration space
  localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;

  typedef struct packed {
    logic shift;   // load the key of the lower neighbor
    logic valid;   // cell lies inside the occupied part of the row
  } cell_ctl_t;

  // fold A-Z to lower case, drop bytes past KEY_CHARS
  function automatic logic [KEY_W-1:0] fold_key(input logic [IN_KEY_W-1:0] raw);
    logic [KEY_W-1:0] res;
    logic [7:0]       b;
    res = '0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      b = raw[8*i +: 8];
      if (b >= 8'h41 && b <= 8'h5A) begin
        b = b + 8'h20;
      end
      res[8*i +: 8] = b;
    end
    return res;
  endfunction

endpackage

// ===== rtl/lkc_cell.sv =====
// ----------------------------------------------------------------------------
// lkc_cell: one slot of the recency-ordered key row
// Holds one folded key, compares it with the lookup key, and on a shift
// takes the key of its more recent neighbor.
// ----------------------------------------------------------------------------
module lkc_cell (
  input  logic                     clk,
  input  lkc_pkg::cell_ctl_t       ctl,
  input  logic [lkc_pkg::KEY_W-1:0] lookup_key,
  input  logic [lkc_pkg::KEY_W-1:0] prev_key,
  output logic [lkc_pkg::KEY_W-1:0] key,
  output logic                     match
);
  import lkc_pkg::*;

  logic [KEY_W-1:0] key_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r <= prev_key;
    end
  end

  assign key   = key_r;
  assign match = ctl.valid && (key_r == lookup_key);

endmodule

// ===== rtl/lru_key_cache_cost_unit.sv =====
// ----------------------------------------------------------------------------
// lru_key_cache_cost_unit: fully associative LRU cache of short text keys
// A row of cells kept in recency order; each beat reports hit, eviction
// and access cost.
//
//   channel  direction  payload                     handshake
//   in       input      in_key[63:0]                in_valid / in_ready
//   out      output     out_hit, out_evicted,       out_valid / out_ready
//                       out_cost[2:0]
//   cfg      input      APB write/read, capacity    psel/penable/pwrite/pready
//
// One beat per cycle while in_ready is high: a key is looked up against all
// cells, the row shifts and the result register loads at the same edge.
// in_ready drops only while a finished result waits on out_ready.
// Synchronous active-low reset empties the row and sets capacity to 32.
// ----------------------------------------------------------------------------
module lru_key_cache_cost_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lkc_pkg::IN_KEY_W-1:0]  in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic                          out_evicted,
  output logic [lkc_pkg::COST_W-1:0]    out_cost,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lkc_pkg::ADDR_W-1:0]    paddr,
  input  logic [lkc_pkg::DATA_W-1:0]    pwdata,
  output logic [lkc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import lkc_pkg::*;

  logic [CAP_W-1:0]  capacity_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              out_evicted_r, out_evicted_nxt;
  logic [COST_W-1:0] out_cost_r, out_cost_nxt;

  logic [KEY_W-1:0]   lookup_key;
  logic [KEY_W-1:0]   cell_key [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  cell_ctl_t          cell_ctl [ENTRIES];

  logic [CMP_W-1:0]  cap_eff;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              accept;
  logic              update;
  logic              hit_c;
  logic              evict_c;
  logic [IDX_W-1:0]  match_idx;
  logic [CNT_W-1:0]  shift_lim;
  logic              cfg_wr;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_CAPACITY);
  assign prdata = DATA_W'(capacity_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  // ---------------------------------------------------------------- lookup
  assign lookup_key = fold_key(in_key);
  assign in_ready   = !out_valid_r || out_ready;
  assign accept     = in_valid && in_ready;

  assign cap_ext = CMP_W'(capacity_r);
  assign cnt_ext = CMP_W'(count_r);
  assign cap_eff = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;

  assign update  = accept && (cap_eff != '0);
  assign hit_c   = |match_vec;
  assign evict_c = !hit_c && (count_r != '0) && (cnt_ext >= cap_eff);

  // matches are unique, so an OR of the indexes encodes the hit position
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        match_idx = match_idx | IDX_W'(i);
      end
    end
  end

  // highest cell that takes its neighbor's key this beat
  always_comb begin
    if (hit_c) begin
      shift_lim = CNT_W'(match_idx);
    end else if (evict_c) begin
      shift_lim = count_r - CNT_W'(1);
    end else begin
      shift_lim = count_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (update && !hit_c && !evict_c) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------- row
  for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
    logic [KEY_W-1:0] prev_key;

    assign cell_ctl[gi].valid = (CNT_W'(gi) < count_r);
    assign cell_ctl[gi].shift = update && (CNT_W'(gi) <= shift_lim);

    if (gi == 0) begin : g_head
      assign prev_key = lookup_key;
    end else begin : g_body
      assign prev_key = cell_key[gi-1];
    end

    lkc_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[gi]),
      .lookup_key (lookup_key),
      .prev_key   (prev_key),
      .key        (cell_key[gi]),
      .match      (match_vec[gi])
    );
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_hit_nxt     = out_hit_r;
    out_evicted_nxt = out_evicted_r;
    out_cost_nxt    = out_cost_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt   = 1'b1;
      out_hit_nxt     = update && hit_c;
      out_evicted_nxt = update && evict_c;
      out_cost_nxt    = (update && hit_c) ? COST_HIT : COST_MISS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r     <= out_hit_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_cost_r    <= out_cost_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_evicted = out_evicted_r;
  assign out_cost    = out_cost_r;

  // ---------------------------------------------------------------- checks
  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one cell matches the lookup key");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(ENTRIES))
    else $error("occupancy above row length");

  a_hit_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (update && (hit_c || evict_c)) |=> (count_r == $past(count_r)))
    else $error("occupancy changed on a hit or an eviction");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (update && !hit_c && !evict_c) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert without eviction did not grow occupancy");

  a_cost_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_hit_r && out_cost_r == COST_HIT && !out_evicted_r) ||
                     (!out_hit_r && out_cost_r == COST_MISS)))
    else $error("result fields disagree");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for the LRU key cache cost unit
// Checks hit, eviction and cost against a cycle-free model of the cache.
// A directed table covers edge keys, case folding and capacity corners.
// Random traffic follows, drawn from a small key pool so hits and
// evictions are frequent. Capacity changes between phases, and sender
// and receiver idle at random.
// ----------------------------------------------------------------------------
module tb;
  import lkc_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [COST_W-1:0] cost;
  } lookup_t;

  typedef enum logic [1:0] {ROW_KEY, ROW_CAP, ROW_SPARE} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [IN_KEY_W-1:0]   data;
    logic                  typed;
    lookup_t               res;
  } dir_row_t;

  localparam logic [ADDR_W-1:0] ADDR_SPARE = 2'd3;
  localparam int POOL_N   = 48;
  localparam int BLOCKS   = 20;
  localparam int BLK_KEYS = 75;
  localparam int DRAIN_MAX = 20000;

  localparam lookup_t LK_NONE  = '0;
  localparam lookup_t LK_MISS  = '{1'b0, 1'b0, COST_MISS};
  localparam lookup_t LK_EVICT = '{1'b0, 1'b1, COST_MISS};
  localparam lookup_t LK_HIT   = '{1'b1, 1'b0, COST_HIT};

  localparam int DIR_N = 26;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{ROW_KEY,   64'h0,                  1'b1, LK_MISS},
    '{ROW_KEY,   64'h0,                  1'b1, LK_HIT},
    '{ROW_KEY,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, LK_MISS},
    '{ROW_KEY,   64'h0043_4241,          1'b1, LK_MISS},   // "ABC"
    '{ROW_KEY,   64'h0063_6261,          1'b1, LK_HIT},    // "abc" folds onto it
    '{ROW_KEY,   64'h5B5A_4140,          1'b0, LK_NONE},   // fold boundaries
    '{ROW_KEY,   64'h5B7A_6140,          1'b1, LK_HIT},
    '{ROW_KEY,   64'h0000_7B60,          1'b0, LK_NONE},
    '{ROW_KEY,   64'h4847_4645_4443_4241, 1'b0, LK_NONE},
    '{ROW_KEY,   64'h6867_6665_6463_6261, 1'b1, LK_HIT},
    '{ROW_CAP,   64'h0,                  1'b0, LK_NONE},   // storing disabled
    '{ROW_KEY,   64'h0063_6261,          1'b1, LK_MISS},
    '{ROW_KEY,   64'h0,                  1'b1, LK_MISS},
    '{ROW_CAP,   64'h1,                  1'b0, LK_NONE},   // below occupancy
    '{ROW_KEY,   64'h007A_7A7A,          1'b1, LK_EVICT},
    '{ROW_KEY,   64'h005A_5A5A,          1'b1, LK_HIT},
    '{ROW_KEY,   64'h0063_6261,          1'b0, LK_NONE},
    '{ROW_CAP,   64'h3F,                 1'b0, LK_NONE},   // saturates
    '{ROW_KEY,   64'h8000_0000_0000_00C1, 1'b0, LK_NONE},
    '{ROW_KEY,   64'h8000_0000_0000_00C1, 1'b1, LK_HIT},
    '{ROW_SPARE, 64'h0,                  1'b0, LK_NONE},   // unmapped, dropped
    '{ROW_KEY,   64'h1,                  1'b0, LK_NONE},
    '{ROW_CAP,   64'hFFFF_FFC2,          1'b0, LK_NONE},
    '{ROW_KEY,   64'h007A_7A7A,          1'b0, LK_NONE},
    '{ROW_KEY,   64'h0000_4141,          1'b0, LK_NONE},
    '{ROW_KEY,   64'h0102_0304_0506_0708, 1'b0, LK_NONE}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [IN_KEY_W-1:0] in_key;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic                out_evicted;
  logic [COST_W-1:0]   out_cost;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // cache image kept by the bench
  logic [KEY_W-1:0]    cache_keys [ENTRIES];
  logic                cache_live [ENTRIES];
  int                  cache_rank [ENTRIES];
  int                  cache_fill;
  logic [CAP_W-1:0]    cap_reg;

  lookup_t             pending_res [$];
  logic [IN_KEY_W-1:0] key_pool [POOL_N];
  int                  err_cnt = 0;
  int                  tx_pct = 0;
  int                  rx_pct = 0;

  lru_key_cache_cost_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_hit     (out_hit),
    .out_evicted (out_evicted),
    .out_cost    (out_cost),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_pct);
  end

  // look up one key and apply the recency update
  function automatic lookup_t predict_access(input logic [IN_KEY_W-1:0] raw);
    logic [KEY_W-1:0] k;
    logic [7:0]       ch;
    lookup_t          r;
    int               lim;
    int               hit_at;
    int               lru_at;
    int               free_at;
    int               old_rank;
    k = '0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      ch = raw[8*i +: 8];
      if (ch >= 8'h41 && ch <= 8'h5A) begin
        ch = ch + 8'h20;
      end
      k[8*i +: 8] = ch;
    end
    lim = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
    r = LK_MISS;
    if (lim == 0) begin
      return r;
    end
    hit_at = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_live[i] && cache_keys[i] == k) begin
        hit_at = i;
      end
    end
    if (hit_at >= 0) begin
      old_rank = cache_rank[hit_at];
      for (int i = 0; i < ENTRIES; i++) begin
        if (cache_live[i] && cache_rank[i] < old_rank) begin
          cache_rank[i]++;
        end
      end
      cache_rank[hit_at] = 0;
      return LK_HIT;
    end
    // full or over capacity: drop exactly one oldest entry
    if (cache_fill >= lim && cache_fill > 0) begin
      lru_at = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (cache_live[i] && (lru_at < 0 || cache_rank[i] > cache_rank[lru_at])) begin
          lru_at = i;
        end
      end
      if (lru_at >= 0) begin
        cache_live[lru_at] = 1'b0;
        cache_rank[lru_at] = 0;
        cache_fill--;
        r.evicted = 1'b1;
      end
    end
    free_at = -1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!cache_live[i]) begin
        free_at = i;
      end
    end
    if (free_at >= 0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (cache_live[i]) begin
          cache_rank[i]++;
        end
      end
      cache_live[free_at] = 1'b1;
      cache_keys[free_at] = k;
      cache_rank[free_at] = 0;
      cache_fill++;
    end
    return r;
  endfunction

  function automatic logic [IN_KEY_W-1:0] rand_text(input logic mixed);
    logic [IN_KEY_W-1:0] t;
    int                  len;
    t = '0;
    len = $urandom_range(KEY_CHARS, 1);
    for (int i = 0; i < len; i++) begin
      if (mixed && $urandom_range(3) == 0) begin
        t[8*i +: 8] = 8'($urandom_range(8'h7E, 8'h21));
      end else begin
        t[8*i +: 8] = 8'($urandom_range(8'h7A, 8'h61));
      end
    end
    return t;
  endfunction

  // hold off until every issued key has its result, then settle
  task automatic wait_drained();
    int n;
    n = 0;
    do begin
      @(posedge clk);
      n++;
    end while (pending_res.size() != 0 && n < DRAIN_MAX);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_capacity(input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] rd;
    in_valid <= 1'b0;
    wait_drained();
    apb_xfer(1'b1, addr, val, rd);
    if (addr == REG_CAPACITY) begin
      cap_reg = val[CAP_W-1:0];
    end
    apb_xfer(1'b0, REG_CAPACITY, '0, rd);
    if (rd !== DATA_W'(cap_reg)) begin
      err_cnt++;
      $display("%0t: capacity readback expected %0d actual %0d", $time, cap_reg, rd);
    end
  endtask

  task automatic drive_key(input logic [IN_KEY_W-1:0] k, input logic typed,
                           input lookup_t fixed);
    lookup_t p;
    if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_pct);
    end
    in_valid <= 1'b1;
    in_key   <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_access(k);
    pending_res.push_back(typed ? fixed : p);
  endtask

  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with none expected, actual hit=%0b evicted=%0b cost=%0d",
                 $time, out_hit, out_evicted, out_cost);
      end else begin
        want = pending_res.pop_front();
        if (out_hit !== want.hit) begin
          err_cnt++;
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, out_hit);
        end
        if (out_evicted !== want.evicted) begin
          err_cnt++;
          $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, out_evicted);
        end
        if (out_cost !== want.cost) begin
          err_cnt++;
          $display("%0t: cost expected %0d actual %0d", $time, want.cost, out_cost);
        end
      end
    end
  end

  initial begin
    logic [IN_KEY_W-1:0] k;
    int                  cap_pick;
    int                  pool_n;
    int                  pick;
    in_valid = 1'b0;
    in_key   = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      cache_keys[i] = '0;
      cache_live[i] = 1'b0;
      cache_rank[i] = 0;
    end
    cache_fill = 0;
    cap_reg    = CAP_RESET;
    for (int i = 0; i < POOL_N; i++) begin
      key_pool[i] = rand_text($urandom_range(4) == 0);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      case (DIR_TAB[r].kind)
        ROW_KEY: begin
          drive_key(DIR_TAB[r].data, DIR_TAB[r].typed, DIR_TAB[r].res);
        end
        ROW_CAP: begin
          write_capacity(REG_CAPACITY, DIR_TAB[r].data[DATA_W-1:0]);
        end
        default: begin
          write_capacity(ADDR_SPARE, DIR_TAB[r].data[DATA_W-1:0]);
        end
      endcase
    end

    for (int blk = 0; blk < BLOCKS; blk++) begin
      case (blk / 5)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 71; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 71; end
        default: begin tx_pct = 38; rx_pct = 38; end
      endcase
      case (blk)
        0: cap_pick = 32;
        1: cap_pick = 63;
        2: cap_pick = 1;
        3: cap_pick = 0;
        4: cap_pick = 2;
        5: cap_pick = 33;
        default: cap_pick = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(40, 1));
      endcase
      write_capacity(REG_CAPACITY, ($urandom() & ~32'h3F) | DATA_W'(cap_pick[CAP_W-1:0]));
      pool_n = $urandom_range(POOL_N, 2);
      for (int it = 0; it < BLK_KEYS; it++) begin
        // now and then let the pipe run dry mid-phase
        if ($urandom_range(199) == 0) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
          k = key_pool[$urandom_range(pool_n - 1)];
          for (int j = 0; j < KEY_CHARS; j++) begin
            if (k[8*j +: 8] >= 8'h61 && k[8*j +: 8] <= 8'h7A && $urandom_range(1)) begin
              k[8*j +: 8] = k[8*j +: 8] - 8'h20;
            end
          end
        end else if (pick < 93) begin
          k = {$urandom(), $urandom()};
        end else begin
          k = rand_text(1'b1);
        end
        drive_key(k, 1'b0, LK_NONE);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_res.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d results never arrived", $time, pending_res.size());
    end
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule
